/* sv/mpow_pkg.sv */
// Shared types and constants for the matrix power block.
package mpow_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned ExpW  = 31;
  localparam int unsigned DimW  = 4;
  localparam logic [DimW-1:0] DimReset = 4'd8;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_INIT,
    ST_CHECK,
    ST_MUL_RD,
    ST_MUL_WAIT,
    ST_MUL_ACC,
    ST_MUL_WR,
    ST_COPY_RD,
    ST_COPY_WR,
    ST_SHIFT,
    ST_OUT_RD,
    ST_OUT_SHOW
  } state_e;

  // Destination of a product and the source pair.
  typedef enum logic [1:0] {
    MUL_NONE,
    MUL_ACC,
    MUL_SQR
  } mul_kind_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       load_we;
    logic       init_we;
    logic       clr_sum;
    logic       acc_en;
    logic       scr_we;
    logic       copy_we;
    logic       copy_to_acc;
    logic       out_rd;
    logic       work_copy;
  } dp_cmd_t;

endpackage

/* sv/mpow_if.sv */
// Valid/ready channel interfaces for the matrix power block.
interface mpow_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] element;
  logic [30:0] exponent;
  logic        last_element;
  modport source (output valid, element, exponent, last_element, input ready);
  modport sink   (input valid, element, exponent, last_element, output ready);
endinterface

interface mpow_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] result_element;
  logic        result_last;
  modport source (output valid, result_element, result_last, input ready);
  modport sink   (input valid, result_element, result_last, output ready);
endinterface

interface mpow_cfg_if;
  logic       valid;
  logic       ready;
  logic [3:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

/* sv/mpow_datapath.sv */
// Matrix stores and multiply-accumulate datapath.
module mpow_datapath import mpow_pkg::*; #(
  parameter int unsigned MaxDim = 8,
  parameter int unsigned IdxW = 3,
  parameter int unsigned AddrW = 6
) (
  input  logic              clk_i,
  input  dp_cmd_t           cmd_i,
  input  logic [IdxW-1:0]   row_i,
  input  logic [IdxW-1:0]   col_i,
  input  logic [IdxW-1:0]   k_i,
  input  logic              sqr_i,
  input  logic [DataW-1:0]  elem_i,
  output logic [DataW-1:0]  rd_o
);
  localparam int unsigned Depth = MaxDim * MaxDim;

  logic [DataW-1:0] base_mem [Depth];
  logic [DataW-1:0] work_mem [Depth];
  logic [DataW-1:0] accw_mem [Depth];
  logic [DataW-1:0] acc_mem  [Depth];
  logic [DataW-1:0] scr_mem  [Depth];
  logic [DataW-1:0] a_q, b_q, p_q, sum_q, rd_q, base_rd_q;

  logic [AddrW-1:0] rc_addr, rk_addr, kc_addr, wc_addr_q;
  assign rc_addr = AddrW'(row_i * MaxDim + col_i);
  assign rk_addr = AddrW'(row_i * MaxDim + k_i);
  assign kc_addr = AddrW'(k_i * MaxDim + col_i);

  // Base store: written on load, read while copying into the work store.
  // The copy lands in the cycle after the read, at the delayed address.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_we) base_mem[rc_addr] <= elem_i;
    base_rd_q <= base_mem[rc_addr];
    wc_addr_q <= rc_addr;
  end

  // Work store (base being squared): its one read port feeds the column operand.
  always_ff @(posedge clk_i) begin
    if (cmd_i.work_copy) work_mem[wc_addr_q] <= base_rd_q;
    else if (cmd_i.copy_we && !cmd_i.copy_to_acc) work_mem[rc_addr] <= rd_q;
    b_q <= work_mem[kc_addr];
  end

  // Copy of the work store read at the row operand address for squaring.
  always_ff @(posedge clk_i) begin
    if (cmd_i.work_copy) accw_mem[wc_addr_q] <= base_rd_q;
    else if (cmd_i.copy_we && !cmd_i.copy_to_acc) accw_mem[rc_addr] <= rd_q;
  end

  logic [DataW-1:0] aw_q, aa_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.init_we) acc_mem[rc_addr] <= (row_i == col_i) ? 32'd1 : 32'd0;
    else if (cmd_i.copy_we && cmd_i.copy_to_acc) acc_mem[rc_addr] <= rd_q;
    aa_q <= acc_mem[rk_addr];
  end
  always_ff @(posedge clk_i) aw_q <= accw_mem[rk_addr];

  always_ff @(posedge clk_i) begin
    if (cmd_i.scr_we) scr_mem[rc_addr] <= sum_q;
    rd_q <= cmd_i.out_rd ? acc_mem[rc_addr] : scr_mem[rc_addr];
  end

  assign a_q = sqr_i ? aw_q : aa_q;

  always_ff @(posedge clk_i) begin
    p_q <= a_q * b_q;
    if (cmd_i.clr_sum) sum_q <= '0;
    else if (cmd_i.acc_en) sum_q <= sum_q + p_q;
  end

  assign rd_o = rd_q;
endmodule

/* sv/mpow_ctrl.sv */
// Sequencer for load, exponent loop, multiply and result output.
module mpow_ctrl import mpow_pkg::*; #(
  parameter int unsigned MaxDim = 8,
  parameter int unsigned IdxW = 3
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [DimW-1:0]  dim_cfg_i,
  input  logic             in_fire_i,
  input  logic             in_last_i,
  input  logic [ExpW-1:0]  in_exp_i,
  input  logic             out_ready_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  output logic             out_last_o,
  output dp_cmd_t          cmd_o,
  output logic [IdxW-1:0]  row_o,
  output logic [IdxW-1:0]  col_o,
  output logic [IdxW-1:0]  k_o,
  output logic             sqr_o
);
  localparam logic [IdxW:0] MaxD = (IdxW+1)'(MaxDim);
  localparam int unsigned LdW = 2 * IdxW + 1;

  state_e state_q, state_d;
  logic [IdxW-1:0] row_q, row_d, col_q, col_d, k_q, k_d;
  logic [LdW-1:0] ld_q, ld_d, ld_total, ld_idx, ld_next;
  logic [IdxW-1:0] ld_row, ld_col;
  logic [ExpW-1:0] exp_q, exp_d;
  logic sqr_q, sqr_d;
  logic [1:0] pipe_q, pipe_d;
  logic [IdxW:0] dim;
  logic [IdxW-1:0] dmax;
  logic wc_q;

  always_comb begin
    if (dim_cfg_i == '0) dim = (IdxW+1)'(1);
    else if ({1'b0, dim_cfg_i} > {1'b0, DimW'(MaxD)}) dim = MaxD;
    else dim = (IdxW+1)'(dim_cfg_i);
    dmax = IdxW'(dim - 1'b1);
  end

  // The load position is a linear count, so a dimension change in the middle
  // of a load maps it onto the new row length. Row and column come from
  // comparing against the multiples of the dimension.
  always_comb begin
    ld_total = LdW'(dim) * LdW'(dim);
    ld_idx = (ld_q >= ld_total) ? '0 : ld_q;
    ld_next = ld_idx + 1'b1;
    if (ld_next >= ld_total) ld_next = '0;
    ld_row = '0;
    for (int m = 1; m < int'(MaxDim); m++) begin
      if (ld_idx >= LdW'(m) * LdW'(dim)) ld_row = ld_row + 1'b1;
    end
    ld_col = IdxW'(ld_idx - LdW'(ld_row) * LdW'(dim));
  end

  always_comb begin
    state_d = state_q;
    row_d = row_q; col_d = col_q; k_d = k_q;
    ld_d = ld_q; exp_d = exp_q; sqr_d = sqr_q; pipe_d = pipe_q;
    case (state_q)
      ST_LOAD: begin
        if (in_fire_i) begin
          if (in_last_i) begin
            ld_d = '0; exp_d = in_exp_i;
            row_d = '0; col_d = '0; state_d = ST_INIT;
          end else begin
            ld_d = ld_next;
          end
        end
      end
      ST_INIT: begin
        if (col_q == dmax) begin
          col_d = '0;
          if (row_q == dmax) begin row_d = '0; state_d = ST_CHECK; end
          else row_d = row_q + 1'b1;
        end else col_d = col_q + 1'b1;
      end
      ST_CHECK: begin
        row_d = '0; col_d = '0; k_d = '0; pipe_d = '0;
        if (exp_q == '0) state_d = ST_OUT_RD;
        else if (exp_q[0]) begin sqr_d = 1'b0; state_d = ST_MUL_RD; end
        else state_d = ST_SHIFT;
      end
      ST_MUL_RD: begin
        if (k_q == dmax) state_d = ST_MUL_WAIT;
        else k_d = k_q + 1'b1;
      end
      ST_MUL_WAIT: begin
        pipe_d = pipe_q + 1'b1;
        if (pipe_q == 2'd2) state_d = ST_MUL_WR;
      end
      ST_MUL_ACC: state_d = ST_MUL_WR;
      ST_MUL_WR: begin
        k_d = '0; pipe_d = '0;
        if (col_q == dmax) begin
          col_d = '0;
          if (row_q == dmax) begin row_d = '0; state_d = ST_COPY_RD; end
          else begin row_d = row_q + 1'b1; state_d = ST_MUL_RD; end
        end else begin col_d = col_q + 1'b1; state_d = ST_MUL_RD; end
      end
      ST_COPY_RD: state_d = ST_COPY_WR;
      ST_COPY_WR: begin
        if (col_q == dmax) begin
          col_d = '0;
          if (row_q == dmax) begin
            row_d = '0;
            state_d = sqr_q ? ST_CHECK : ST_SHIFT;
          end else begin row_d = row_q + 1'b1; state_d = ST_COPY_RD; end
        end else begin col_d = col_q + 1'b1; state_d = ST_COPY_RD; end
      end
      ST_SHIFT: begin
        exp_d = exp_q >> 1;
        if ((exp_q >> 1) == '0) state_d = ST_OUT_RD;
        else begin sqr_d = 1'b1; state_d = ST_MUL_RD; end
        k_d = '0; row_d = '0; col_d = '0; pipe_d = '0;
        if (sqr_q && state_q == ST_SHIFT) sqr_d = ((exp_q >> 1) != '0);
      end
      ST_OUT_RD: state_d = ST_OUT_SHOW;
      ST_OUT_SHOW: begin
        if (out_ready_i) begin
          if (col_q == dmax) begin
            col_d = '0;
            if (row_q == dmax) begin row_d = '0; state_d = ST_LOAD; end
            else begin row_d = row_q + 1'b1; state_d = ST_OUT_RD; end
          end else begin col_d = col_q + 1'b1; state_d = ST_OUT_RD; end
        end
      end
      default: state_d = ST_LOAD;
    endcase
    // A squaring pass returns to CHECK with the exponent, already shifted in SHIFT, unchanged.
    if (state_q == ST_COPY_WR && state_d == ST_CHECK) exp_d = exp_q;
  end

  // Work-store refresh from the base happens during INIT. Products pass through the
  // operand registers and the product register before the sum, so accumulation lags the k sweep.
  always_comb begin
    cmd_o = '0;
    row_o = row_q; col_o = col_q; k_o = k_q; sqr_o = sqr_q;
    in_ready_o = 1'b0; out_valid_o = 1'b0;
    out_last_o = (row_q == dmax) && (col_q == dmax);
    case (state_q)
      ST_LOAD: begin
        in_ready_o = 1'b1;
        row_o = ld_row; col_o = ld_col;
        cmd_o.load_we = in_fire_i;
      end
      ST_INIT: cmd_o.init_we = 1'b1;
      ST_MUL_RD: begin
        cmd_o.acc_en = (k_q > IdxW'(1));
        cmd_o.clr_sum = (k_q == '0);
      end
      ST_MUL_WAIT: cmd_o.acc_en = (pipe_q != 2'd2) && !(pipe_q == 2'd0 && dmax == '0);
      ST_MUL_ACC: cmd_o.acc_en = 1'b1;
      ST_MUL_WR: cmd_o.scr_we = 1'b1;
      ST_COPY_WR: begin cmd_o.copy_we = 1'b1; cmd_o.copy_to_acc = !sqr_q; end
      ST_OUT_RD: cmd_o.out_rd = 1'b1;
      ST_OUT_SHOW: begin out_valid_o = 1'b1; cmd_o.out_rd = 1'b1; end
      default: ;
    endcase
    cmd_o.work_copy = wc_q;
  end

  // wc_q marks the cycle after each INIT step, when the base read lands in
  // the work store.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) wc_q <= 1'b0;
    else wc_q <= (state_q == ST_INIT);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      row_q <= '0; col_q <= '0; k_q <= '0; ld_q <= '0;
      exp_q <= '0; sqr_q <= 1'b0; pipe_q <= '0;
    end else begin
      state_q <= state_d;
      row_q <= row_d; col_q <= col_d; k_q <= k_d; ld_q <= ld_d;
      exp_q <= exp_d; sqr_q <= sqr_d; pipe_q <= pipe_d;
    end
  end
endmodule

/* sv/matrix_power_by_squaring_top.sv */
// Top level of the matrix power block.
//   channel  dir  signals
//   in_if    in   element, exponent, last_element
//   out_if   out  result_element, result_last
//   cfg_if   in   data (matrix_dim)
// Loading accepts an element whenever the input is valid. A compute then sets
// up the identity and the working copy of the base, then runs one multiply
// per set exponent bit and one squaring per bit below the highest. Each
// multiply does d reads, a pipeline wait and one write per element, then a
// copy read and write per element; each result is then read and shown.
// Reset is asynchronous and active low; input is held not ready while
// computing, and output stalls simply hold the current result.
module matrix_power_by_squaring_top import mpow_pkg::*; #(
  parameter int unsigned MaxDim = 8
) (
  input  logic clk_i,
  input  logic rst_ni,
  mpow_in_if.sink    in_if,
  mpow_out_if.source out_if,
  mpow_cfg_if.sink   cfg_if
);
  localparam int unsigned IdxW = (MaxDim > 1) ? $clog2(MaxDim) : 1;
  localparam int unsigned AddrW = (MaxDim > 1) ? $clog2(MaxDim * MaxDim) : 1;

  logic [DimW-1:0] dim_q;
  dp_cmd_t cmd;
  logic [IdxW-1:0] row, col, k;
  logic sqr, in_fire;

  assign cfg_if.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) dim_q <= DimReset;
    else if (cfg_if.valid) dim_q <= cfg_if.data;
  end

  assign in_fire = in_if.valid && in_if.ready;

  mpow_ctrl #(.MaxDim(MaxDim), .IdxW(IdxW)) u_ctrl (
    .clk_i, .rst_ni, .dim_cfg_i(dim_q), .in_fire_i(in_fire),
    .in_last_i(in_if.last_element), .in_exp_i(in_if.exponent),
    .out_ready_i(out_if.ready), .in_ready_o(in_if.ready),
    .out_valid_o(out_if.valid), .out_last_o(out_if.result_last),
    .cmd_o(cmd), .row_o(row), .col_o(col), .k_o(k), .sqr_o(sqr)
  );

  mpow_datapath #(.MaxDim(MaxDim), .IdxW(IdxW), .AddrW(AddrW)) u_dp (
    .clk_i, .cmd_i(cmd), .row_i(row), .col_i(col), .k_i(k), .sqr_i(sqr),
    .elem_i(in_if.element), .rd_o(out_if.result_element)
  );
endmodule
